// ===== sv/ate_pkg.sv =====
`default_nettype none

package ate_pkg;

  localparam int MaxBurst = 6;
  localparam int CntW = $clog2(MaxBurst + 1);

  typedef enum logic [3:0] {
    MODE_TEXT = 4'b0001,
    MODE_PCT  = 4'b0010,
    MODE_MOD  = 4'b0100,
    MODE_NUM  = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [MaxBurst-1:0][7:0] chars;
    logic [CntW-1:0]          cnt;
    logic                     last;
  } burst_t;

  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChLBrace  = 8'h7b;
  localparam logic [7:0] ChRBrace  = 8'h7d;
  localparam logic [7:0] ChColon   = 8'h3a;

endpackage

`default_nettype wire

// ===== sv/asm_template_escape_translator_top.sv =====
// template escape translator
// input channel: in_valid_i / in_ready_o carry one template byte (in_char_i)
// with in_last_i marking the final byte of a template
// output channel: out_valid_o / out_ready_i carry one translated byte
// (out_char_o) with out_last_o on the final word of the template
// each input byte expands into zero to six output words, computed in the
// cycle it is accepted and held in a burst register
// the first word of a burst appears in the cycle after its byte is accepted
// throughput: one input byte per cycle while each byte yields at most one
// word and out_ready_i is high; a byte that yields several words holds the
// burst register until its last word is taken, one word per ready cycle
// bytes yielding no word (escape lead-ins) load nothing into the register
// reset: scan state returns to plain text, the burst register is emptied
// receiver stall: the current word holds, in_ready_o drops once the
// burst register has no free slot for the next byte
`default_nettype none

module asm_template_escape_translator_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_char_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            out_last_o
);

  ate_pkg::mode_e  mode_q, mode_d;
  logic [7:0]      held_q, held_d;
  ate_pkg::burst_t burst;
  logic            accept;
  logic            load;
  logic            can_load;

  ate_expander u_expander (
    .mode_i  (mode_q),
    .held_i  (held_q),
    .char_i  (in_char_i),
    .last_i  (in_last_i),
    .burst_o (burst),
    .mode_o  (mode_d),
    .held_o  (held_d)
  );

  assign in_ready_o = can_load;
  assign accept     = in_valid_i && can_load;
  assign load       = accept && (burst.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ate_pkg::MODE_TEXT;
      held_q <= 8'h00;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

  ate_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .burst_i     (burst),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o)
  );

`ifndef NO_ASSERTIONS
  a_last_resets_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |=> (mode_q == ate_pkg::MODE_TEXT && held_q == 8'h00))
    else $error("scan state not cleared after final byte");

  a_last_yields_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |-> load)
    else $error("final byte produced no word");

  a_held_only_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ate_pkg::MODE_TEXT || mode_q == ate_pkg::MODE_PCT) |-> (held_q == 8'h00))
    else $error("modifier held outside an escape");
`endif

endmodule

`default_nettype wire

// ===== sv/ate_expander.sv =====
`default_nettype none

module ate_expander (
  input  wire ate_pkg::mode_e  mode_i,
  input  wire logic [7:0]      held_i,
  input  wire logic [7:0]      char_i,
  input  wire logic            last_i,
  output ate_pkg::burst_t      burst_o,
  output ate_pkg::mode_e       mode_o,
  output logic [7:0]           held_o
);

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic ate_pkg::burst_t put(ate_pkg::burst_t b, logic [7:0] c);
    ate_pkg::burst_t r;
    r = b;
    r.chars[b.cnt] = c;
    r.cnt = b.cnt + ate_pkg::CntW'(1);
    return r;
  endfunction

  function automatic ate_pkg::burst_t close_op(ate_pkg::burst_t b, logic [7:0] h);
    ate_pkg::burst_t r;
    r = b;
    if (h != 8'h00) begin
      r = put(r, ate_pkg::ChColon);
      r = put(r, h);
      r = put(r, ate_pkg::ChRBrace);
    end
    return r;
  endfunction

  logic plain;
  ate_pkg::burst_t b;
  ate_pkg::mode_e  nmode;
  logic [7:0]      nheld;

  always_comb begin
    b     = '0;
    nmode = mode_i;
    nheld = held_i;
    plain = 1'b0;
    unique case (mode_i)
      ate_pkg::MODE_PCT: begin
        if (char_i == ate_pkg::ChPercent) begin
          b = put(b, ate_pkg::ChPercent);
          nmode = ate_pkg::MODE_TEXT;
        end else if (is_digit(char_i)) begin
          b = put(b, ate_pkg::ChDollar);
          b = put(b, char_i);
          nheld = 8'h00;
          nmode = ate_pkg::MODE_NUM;
        end else if (is_letter(char_i) && !last_i) begin
          nheld = char_i;
          nmode = ate_pkg::MODE_MOD;
        end else begin
          b = put(b, ate_pkg::ChPercent);
          plain = 1'b1;
        end
      end
      ate_pkg::MODE_MOD: begin
        if (is_digit(char_i)) begin
          b = put(b, ate_pkg::ChDollar);
          b = put(b, ate_pkg::ChLBrace);
          b = put(b, char_i);
          nmode = ate_pkg::MODE_NUM;
        end else begin
          b = put(b, ate_pkg::ChPercent);
          b = put(b, held_i);
          plain = 1'b1;
        end
      end
      ate_pkg::MODE_NUM: begin
        if (is_digit(char_i)) begin
          b = put(b, char_i);
        end else begin
          b = close_op(b, held_i);
          plain = 1'b1;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase

    if (plain) begin
      nmode = ate_pkg::MODE_TEXT;
      nheld = 8'h00;
      if (char_i == ate_pkg::ChDollar) begin
        b = put(b, ate_pkg::ChDollar);
        b = put(b, ate_pkg::ChDollar);
      end else if (char_i == ate_pkg::ChPercent) begin
        if (last_i) begin
          b = put(b, ate_pkg::ChPercent);
        end else begin
          nmode = ate_pkg::MODE_PCT;
        end
      end else begin
        b = put(b, char_i);
      end
    end

    if (last_i) begin
      if (nmode == ate_pkg::MODE_NUM) begin
        b = close_op(b, nheld);
      end
      b.last = 1'b1;
      nmode = ate_pkg::MODE_TEXT;
      nheld = 8'h00;
    end
  end

  assign burst_o = b;
  assign mode_o  = nmode;
  assign held_o  = nheld;

endmodule

`default_nettype wire

// ===== sv/ate_serializer.sv =====
`default_nettype none

module ate_serializer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire ate_pkg::burst_t burst_i,
  output logic                 can_load_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           out_char_o,
  output logic                 out_last_o
);

  ate_pkg::burst_t           burst_q;
  logic                      valid_q, valid_d;
  logic [ate_pkg::CntW-1:0]  idx_q, idx_d;
  logic                      take;
  logic                      final_beat;

  assign final_beat = (idx_q == (burst_q.cnt - ate_pkg::CntW'(1)));
  assign take       = valid_q && out_ready_i;
  assign can_load_o = !valid_q || (take && final_beat);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (take) begin
      if (final_beat) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + ate_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = burst_q.chars[idx_q];
  assign out_last_o  = burst_q.last && final_beat;

`ifndef NO_ASSERTIONS
  a_idx_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q < burst_q.cnt))
    else $error("beat index beyond burst length");

  a_burst_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((burst_q.cnt != '0) && (burst_q.cnt <= ate_pkg::CntW'(ate_pkg::MaxBurst))))
    else $error("burst length out of range");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o)
    else $error("burst loaded over pending word");

  a_mid_burst_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !final_beat) |=> (valid_q && $stable(burst_q.cnt)))
    else $error("burst dropped before final word");
`endif

endmodule

`default_nettype wire

// ===== tb/asm_template_escape_translator_top_test.sv =====
`timescale 1ns / 100ps

module asm_template_escape_translator_top_test;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } word_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain;
  } tmpl_byte_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_char_i;
  logic       in_last_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_char_o;
  logic       out_last_o;

  tmpl_byte_t      byte_queue[$];
  word_t           exp_words[$];
  ate_pkg::mode_e  esc_state = ate_pkg::MODE_TEXT;
  logic [7:0]      mod_letter = '0;
  bit              in_taken = 1'b0;
  int              accepted = 0;
  int              errors = 0;

  asm_template_escape_translator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_char_i  (in_char_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_char_o (out_char_o),
    .out_last_o (out_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void emit(input logic [7:0] c);
    word_t w;
    w.ch = c;
    w.last = 1'b0;
    exp_words = {exp_words, w};
  endfunction

  function automatic void as_text(input logic [7:0] c, input logic lst);
    esc_state = ate_pkg::MODE_TEXT;
    mod_letter = '0;
    if (c == ate_pkg::ChDollar) begin
      emit(ate_pkg::ChDollar);
      emit(ate_pkg::ChDollar);
    end else if (c == ate_pkg::ChPercent) begin
      if (lst) emit(ate_pkg::ChPercent);
      else esc_state = ate_pkg::MODE_PCT;
    end else begin
      emit(c);
    end
  endfunction

  function automatic void close_operand();
    if (mod_letter != 8'h00) begin
      emit(ate_pkg::ChColon);
      emit(mod_letter);
      emit(ate_pkg::ChRBrace);
    end
  endfunction

  function automatic void translate_byte(input logic [7:0] c, input logic lst);
    int first;
    first = exp_words.size();
    case (esc_state)
      ate_pkg::MODE_PCT: begin
        if (c == ate_pkg::ChPercent) begin
          emit(ate_pkg::ChPercent);
          esc_state = ate_pkg::MODE_TEXT;
        end else if (is_digit(c)) begin
          emit(ate_pkg::ChDollar);
          emit(c);
          mod_letter = '0;
          esc_state = ate_pkg::MODE_NUM;
        end else if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && !lst) begin
          mod_letter = c;
          esc_state = ate_pkg::MODE_MOD;
        end else begin
          emit(ate_pkg::ChPercent);
          as_text(c, lst);
        end
      end
      ate_pkg::MODE_MOD: begin
        if (is_digit(c)) begin
          emit(ate_pkg::ChDollar);
          emit(ate_pkg::ChLBrace);
          emit(c);
          esc_state = ate_pkg::MODE_NUM;
        end else begin
          emit(ate_pkg::ChPercent);
          emit(mod_letter);
          as_text(c, lst);
        end
      end
      ate_pkg::MODE_NUM: begin
        if (is_digit(c)) begin
          emit(c);
        end else begin
          close_operand();
          as_text(c, lst);
        end
      end
      default: as_text(c, lst);
    endcase
    if (lst) begin
      if (esc_state == ate_pkg::MODE_NUM) close_operand();
      if (exp_words.size() > first) exp_words[exp_words.size() - 1].last = 1'b1;
      esc_state = ate_pkg::MODE_TEXT;
      mod_letter = '0;
    end
  endfunction

  task automatic add_byte(input logic [7:0] c, input logic lst, input bit drain);
    tmpl_byte_t b;
    b.ch = c;
    b.last = lst;
    b.drain = drain;
    byte_queue = {byte_queue, b};
  endtask

  task automatic add_str(input string s, input bit lst);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], lst && i == s.len() - 1, 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1)) return 8'("A" + $urandom_range(25));
    return 8'("a" + $urandom_range(25));
  endfunction

  task automatic add_template(input bit drain);
    logic [7:0] t[$];
    int tokens;
    int ndig;
    tokens = $urandom_range(1, 6);
    for (int k = 0; k < tokens; k++) begin
      case ($urandom_range(9)) inside
        0, 1: t = {t, 8'($urandom_range(255))};
        2: t = {t, ate_pkg::ChDollar};
        3: begin
          t = {t, ate_pkg::ChPercent};
          t = {t, ate_pkg::ChPercent};
        end
        [4:6]: begin
          t = {t, ate_pkg::ChPercent};
          if ($urandom_range(4) != 0 || k == 0) begin
            if ($urandom_range(1)) t = {t, rand_letter()};
          end
          ndig = $urandom_range(1, 3);
          for (int j = 0; j < ndig; j++) t = {t, 8'("0" + $urandom_range(9))};
        end
        7: begin
          t = {t, ate_pkg::ChPercent};
          t = {t, rand_letter()};
        end
        8: begin
          t = {t, ate_pkg::ChPercent};
          t = {t, 8'($urandom_range(255))};
        end
        default: t = {t, ate_pkg::ChPercent};
      endcase
    end
    for (int j = 0; j < t.size(); j++) add_byte(t[j], j == t.size() - 1, drain && j == 0);
  endtask

  // driver
  always @(negedge clk_i) begin : drive_blk
    int send_idle;
    int recv_idle;
    tmpl_byte_t b;
    if (accepted < 175) begin
      send_idle = 27;
      recv_idle = 58;
    end else if (accepted < 325) begin
      send_idle = 58;
      recv_idle = 27;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_char_i <= '0;
      in_last_i <= 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_taken) begin
        in_valid_i <= 1'b1;
      end else if (byte_queue.size() != 0
                   && !(byte_queue[0].drain && exp_words.size() != 0)
                   && $urandom_range(99) >= send_idle) begin
        b = byte_queue.pop_front();
        in_valid_i <= 1'b1;
        in_char_i <= b.ch;
        in_last_i <= b.last;
      end else begin
        in_valid_i <= 1'b0;
      end
      out_ready_i <= $urandom_range(99) >= recv_idle;
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin : watch_blk
    word_t w;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (exp_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word char=%h last=%b", out_char_o, out_last_o));
        end else begin
          w = exp_words.pop_front();
          if (out_char_o !== w.ch)
            report_mismatch($sformatf("char got %h want %h", out_char_o, w.ch));
          if (out_last_o !== w.last)
            report_mismatch($sformatf("last got %b want %b (char %h)", out_last_o, w.last, w.ch));
        end
      end
      if (in_valid_i && in_ready_o) begin
        in_taken = 1'b1;
        translate_byte(in_char_i, in_last_i);
        accepted++;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_char_i = '0;
    in_last_i = 1'b0;
    out_ready_i = 1'b0;

    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hff, 1'b0, 1'b0);
    add_str("$%%%12%a3$%Zq%~%$", 1'b0);
    add_str("%", 1'b1);
    add_str("%k", 1'b1);
    add_str("%c7", 1'b1);
    add_template(1'b1);
    while (byte_queue.size() < 445) add_template($urandom_range(14) == 0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_queue.size() != 0 || in_valid_i || exp_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("asm_template_escape_translator_top test passed");
    end else begin
      $display("asm_template_escape_translator_top test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout waiting for words");
    $display("asm_template_escape_translator_top test failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/ate_pkg.sv
sv/ate_expander.sv
sv/ate_serializer.sv
sv/asm_template_escape_translator_top.sv
tb/asm_template_escape_translator_top_test.sv
